// File: hdl/xrf_pkg.sv
// Shared types, constants and codes for the XON/XOFF receive FIFO.
package xrf_pkg;

    // Buffer geometry
    localparam int DEPTH = 8;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 4;
    localparam int FILL_W  = 4;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;

    // Width used when comparing the fill count with a limit
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Byte classes
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;
    localparam logic [BYTE_W-1:0] LF_CODE    = 8'd10;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Flow request codes
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_XOFF = 2'd1;
    localparam logic [REQ_W-1:0] REQ_XON  = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 4'd1;
    localparam logic [LIMIT_W-1:0] UPPER_RESET = 4'd4;
    localparam logic [LIMIT_W-1:0] LOWER_RESET = 4'd1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP_READ,
        ST_POP_CHECK,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;      // latch a new request, clear the result
        logic push;      // perform the push step
        logic pop_read;  // read the head byte and advance
        logic pop_end;   // close the pop and run the XON test
        logic publish;   // load the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;     // no bytes held
        logic skip;      // last byte read is a control byte and more remain
        logic out_free;  // output register can take a result
    } status_t;

endpackage

// File: hdl/xrf_ctrl.sv
// Controller state machine for the XON/XOFF receive FIFO.
module xrf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             op,
    output logic             in_ready,
    input  xrf_pkg::status_t status,
    output xrf_pkg::cmd_t    cmd
);
    import xrf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (op == OP_PUSH)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (status.empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_POP_READ;
                    end
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_POP_READ:
            begin
                cmd.pop_read = 1'b1;
                state_next   = ST_POP_CHECK;
            end
            ST_POP_CHECK:
            begin
                if (status.skip)
                begin
                    state_next = ST_POP_READ;
                end
                else
                begin
                    cmd.pop_end = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A head read is only issued while bytes are held
    a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP_READ |-> !status.empty)
        else $error("pop read issued on an empty buffer");

endmodule

// File: hdl/xrf_datapath.sv
// Datapath of the XON/XOFF receive FIFO: store, pointers, fill count and result register.
module xrf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  xrf_pkg::cmd_t                       cmd,
    output xrf_pkg::status_t                    status,
    input  logic [xrf_pkg::BYTE_W-1:0]          rx_byte,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xrf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [xrf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                accepted,
    output logic                                overflow,
    output logic                                got_byte,
    output logic [xrf_pkg::BYTE_W-1:0]          out_byte,
    output logic [xrf_pkg::REQ_W-1:0]           flow_request,
    output logic [xrf_pkg::FILL_W-1:0]          fill_level
);
    import xrf_pkg::*;

    // Byte store
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Control state
    logic [PTR_W-1:0]   rd_ptr_reg,  rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg,  wr_ptr_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               xoff_reg,    xoff_next;
    logic [LIMIT_W-1:0] upper_reg,   upper_next;
    logic [LIMIT_W-1:0] lower_reg,   lower_next;

    // Request and working result
    logic [BYTE_W-1:0]  rx_reg;
    logic               acc_reg,     acc_next;
    logic               ovf_reg,     ovf_next;
    logic               got_reg,     got_next;
    logic [REQ_W-1:0]   req_reg,     req_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg;
    logic               out_ovf_reg;
    logic               out_got_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [REQ_W-1:0]   out_req_reg;
    logic [FILL_W-1:0]  out_fill_reg;

    logic               full;
    logic               store_en;
    logic [CNT_W-1:0]   count_push;
    logic [CMP_W-1:0]   count_wide;
    logic [CMP_W-1:0]   count_push_wide;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign store_en   = cmd.push && !xoff_reg && !full;
    assign count_push = store_en ? count_reg + 1'b1 : count_reg;
    assign count_wide      = CMP_W'(count_reg);
    assign count_push_wide = CMP_W'(count_push);

    // Report status to the controller
    assign status.empty    = (count_reg == '0);
    assign status.skip     = (rdata_reg < CTRL_LIMIT) && (rdata_reg != LF_CODE)
                             && (count_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    // Store write and registered head read
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[wr_ptr_reg] <= rx_reg;
        end
        if (cmd.pop_read)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    // Latch the pushed byte
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rx_reg <= rx_byte;
        end
    end

    // Next state of pointers, count, flow state and result
    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        xoff_next      = xoff_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        got_next       = got_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;

        // Write configuration; unknown indexes drop
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_UPPER: upper_next = cfg_data;
                CFG_LOWER: lower_next = cfg_data;
                default:   ;
            endcase
        end

        // Clear the result for a new request
        if (cmd.take)
        begin
            acc_next = 1'b0;
            ovf_next = 1'b0;
            got_next = 1'b0;
            req_next = REQ_NONE;
        end

        // Push: store unless XOFF or full, then test for XOFF
        if (cmd.push && !xoff_reg)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                wr_ptr_next = ring_next(wr_ptr_reg);
                acc_next    = 1'b1;
            end
            count_next = count_push;
            if (count_push_wide > CMP_W'(upper_reg))
            begin
                xoff_next = 1'b1;
                req_next  = REQ_XOFF;
            end
        end

        // Pop: advance past the head byte
        if (cmd.pop_read)
        begin
            rd_ptr_next = ring_next(rd_ptr_reg);
            count_next  = count_reg - 1'b1;
        end

        // Close the pop and test for XON
        if (cmd.pop_end)
        begin
            got_next = 1'b1;
            if (count_wide < CMP_W'(lower_reg) && xoff_reg)
            begin
                xoff_next = 1'b0;
                req_next  = REQ_XON;
            end
        end

        // Hand over the result or drop it once taken
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            xoff_reg      <= 1'b0;
            upper_reg     <= UPPER_RESET;
            lower_reg     <= LOWER_RESET;
            acc_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            got_reg       <= 1'b0;
            req_reg       <= REQ_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            xoff_reg      <= xoff_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            got_reg       <= got_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_acc_reg  <= acc_reg;
            out_ovf_reg  <= ovf_reg;
            out_got_reg  <= got_reg;
            out_byte_reg <= got_reg ? rdata_reg : '0;
            out_req_reg  <= req_reg;
            out_fill_reg <= count_wide[FILL_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign overflow     = out_ovf_reg;
    assign got_byte     = out_got_reg;
    assign out_byte     = out_byte_reg;
    assign flow_request = out_req_reg;
    assign fill_level   = out_fill_reg;

    // Fill count never exceeds the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_wide <= CMP_W'(DEPTH))
        else $error("fill count beyond depth");

    // A push under XOFF leaves the buffer untouched
    a_xoff_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && xoff_reg |=> $stable(count_reg) && $stable(wr_ptr_reg))
        else $error("push stored a byte while XOFF in force");

    // A published result is never both stored and refused, nor both push and pop
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> !(accepted && overflow) && !(got_byte && (accepted || overflow)))
        else $error("inconsistent result flags");

endmodule

// File: hdl/xon_xoff_receive_fifo.sv
// Top level of the XON/XOFF receive FIFO: controller and datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: op selects push of
//   rx_byte or pop of the next valid byte. Output channel (out_valid/out_ready)
//   returns one result per request: accepted, overflow, got_byte, out_byte,
//   flow_request (XOFF or XON to be sent now) and fill_level after the step.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the upper limit (index 0) and lower limit (index 1); it is always ready.
// Sequence:
//   A push goes from acceptance through PUSH to FINISH, where its result
//   is loaded once the output register frees. A pop passes POP_READ and
//   POP_CHECK per byte read, then FINISH; an empty pop goes to FINISH.
//   Both are needed per byte: the registered read port feeds the skip test.
// Reset:
//   Pointers, fill count and output valid clear; XON state; limits return to
//   4 and 1. Store contents are undefined until written.
// Stalls:
//   A result waits in the output register while out_ready is low; the block
//   still takes the next request and holds its own result until the register
//   frees.
module xon_xoff_receive_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [xrf_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                accepted,
    output logic                                overflow,
    output logic                                got_byte,
    output logic [xrf_pkg::BYTE_W-1:0]          out_byte,
    output logic [xrf_pkg::REQ_W-1:0]           flow_request,
    output logic [xrf_pkg::FILL_W-1:0]          fill_level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xrf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [xrf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import xrf_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each request
    xrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the bytes, pointers, limits and result
    xrf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .overflow     (overflow),
        .got_byte     (got_byte),
        .out_byte     (out_byte),
        .flow_request (flow_request),
        .fill_level   (fill_level)
    );

endmodule

// File: tb/sv/xon_xoff_receive_fifo_test.sv
// Self-checking testbench for the XON/XOFF receive FIFO with a built-in predictor.
`timescale 1ns / 100ps

module xon_xoff_receive_fifo_test;
    import xrf_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 85;
    localparam int PRINT_LIMIT  = 40;

    // Expected outcome of one request, field for field as the block reports it
    typedef struct packed {
        logic                accepted;
        logic                overflow;
        logic                got_byte;
        logic [BYTE_W-1:0]   out_byte;
        logic [REQ_W-1:0]    flow_request;
        logic [FILL_W-1:0]   fill_level;
    } fifo_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = OP_PUSH;
    logic [BYTE_W-1:0]     rx_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  accepted;
    logic                  overflow;
    logic                  got_byte;
    logic [BYTE_W-1:0]     out_byte;
    logic [REQ_W-1:0]      flow_request;
    logic [FILL_W-1:0]     fill_level;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the buffer, pointers, flow state and limits
    logic [BYTE_W-1:0] shadow_store [DEPTH];
    int                shadow_head = 0;
    int                shadow_tail = 0;
    int                shadow_fill = 0;
    logic              shadow_xoff = 1'b0;
    int                shadow_upper = int'(UPPER_RESET);
    int                shadow_lower = int'(LOWER_RESET);

    fifo_outcome_t     pending_outcomes [$];
    int                mismatch_count = 0;
    int                outcomes_seen = 0;
    logic              steady_flow = 1'b0;

    xon_xoff_receive_fifo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .overflow     (overflow),
        .got_byte     (got_byte),
        .out_byte     (out_byte),
        .flow_request (flow_request),
        .fill_level   (fill_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Advance the shadow FIFO by one request and return what the block should report
    function automatic fifo_outcome_t fifo_step(input logic req_op,
                                                input logic [BYTE_W-1:0] req_byte);
        fifo_outcome_t     res;
        logic [BYTE_W-1:0] taken;
        res = '0;
        taken = '0;
        if (req_op == OP_PUSH)
        begin
            // Refuse everything while XOFF holds; flag a full buffer
            if (!shadow_xoff)
            begin
                if (shadow_fill >= DEPTH)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    shadow_store[shadow_tail] = req_byte;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                    res.accepted = 1'b1;
                end
                if (shadow_fill > shadow_upper)
                begin
                    shadow_xoff = 1'b1;
                    res.flow_request = REQ_XOFF;
                end
            end
        end
        else if (shadow_fill > 0)
        begin
            // Drop control bytes until a valid one or the last byte held
            do
            begin
                taken = shadow_store[shadow_head];
                shadow_head = (shadow_head + 1) % DEPTH;
                shadow_fill--;
            end
            while (taken < CTRL_LIMIT && taken != LF_CODE && shadow_fill > 0);
            res.got_byte = 1'b1;
            res.out_byte = taken;
            if (shadow_fill < shadow_lower && shadow_xoff)
            begin
                shadow_xoff = 1'b0;
                res.flow_request = REQ_XON;
            end
        end
        res.fill_level = shadow_fill[FILL_W-1:0];
        return res;
    endfunction

    // Bias towards control bytes and LF so the skip logic gets plenty of work
    function automatic logic [BYTE_W-1:0] draw_rx_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return BYTE_W'($urandom_range(0, CTRL_LIMIT - 1));
        else if (pick == 4)
            return LF_CODE;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int seen, input int want);
        if (seen != want)
            report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                      outcomes_seen, name, seen, want));
    endtask

    // Send one request, then predict its outcome once it is taken
    task automatic send_request(input logic req_op, input logic [BYTE_W-1:0] req_byte);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        rx_byte  <= req_byte;
        do @(posedge clk); while (!in_ready);
        pending_outcomes.push_back(fifo_step(req_op, req_byte));
    endtask

    // Hold the sender until every outstanding result has been collected
    task automatic wait_for_outcomes();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_UPPER)
            shadow_upper = int'(val);
        else if (idx == CFG_LOWER)
            shadow_lower = int'(val);
    endtask

    // Fill past the reset upper limit, push into XOFF, then drain back to XON
    task automatic test_hysteresis_defaults();
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PUSH, LF_CODE);
        send_request(OP_PUSH, CTRL_LIMIT - 8'd1);
        send_request(OP_PUSH, CTRL_LIMIT);
        send_request(OP_PUSH, 8'h41);
        send_request(OP_POP, 8'hFF);
        send_request(OP_POP, 8'h00);
        send_request(OP_POP, 8'h55);
        send_request(OP_POP, 8'hAA);
    endtask

    // Overflow a full buffer of control bytes, then pop it dry in one request
    task automatic test_overflow_and_skip();
        wait_for_outcomes();
        write_register(CFG_UPPER, 4'hF);
        write_register(4'hF, 4'h0);
        for (int i = 1; i <= DEPTH + 1; i++)
            send_request(OP_PUSH, i[BYTE_W-1:0]);
        send_request(OP_POP, 8'h00);
        send_request(OP_POP, 8'h00);
    endtask

    // XOFF on the second byte; a zero lower limit must not release it
    task automatic test_limit_extremes();
        wait_for_outcomes();
        write_register(CFG_UPPER, 4'd1);
        write_register(CFG_LOWER, 4'd0);
        send_request(OP_PUSH, 8'h7F);
        send_request(OP_PUSH, 8'h80);
        send_request(OP_POP, 8'h00);
        wait_for_outcomes();
        write_register(CFG_LOWER, 4'd8);
        send_request(OP_POP, 8'h00);
    endtask

    // Phases of random traffic, each under its own limits and push bias
    task automatic test_random_traffic();
        int push_pct;
        int upper_val;
        int lower_val;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_outcomes();
            case (phase)
                0:
                begin
                    upper_val = 0;
                    lower_val = 1;
                end
                1:
                begin
                    upper_val = 15;
                    lower_val = 15;
                end
                2:
                begin
                    upper_val = 8;
                    lower_val = 8;
                end
                3:
                begin
                    upper_val = 7;
                    lower_val = 1;
                end
                default:
                begin
                    upper_val = $urandom_range(0, 9);
                    lower_val = $urandom_range(1, 9);
                end
            endcase
            write_register(CFG_UPPER, upper_val[CFG_DATA_W-1:0]);
            write_register(CFG_LOWER, lower_val[CFG_DATA_W-1:0]);
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_IDX_W'($urandom_range(2, 15)),
                               CFG_DATA_W'($urandom_range(0, 15)));
            steady_flow = ($urandom_range(0, 3) == 0);
            push_pct = $urandom_range(30, 75);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_for_outcomes();
                if ($urandom_range(0, 99) < push_pct)
                    send_request(OP_PUSH, draw_rx_byte());
                else
                    send_request(OP_POP, BYTE_W'($urandom_range(0, 255)));
            end
        end
        steady_flow = 1'b0;
    endtask

    // Collect results with random stalls and compare each with the oldest prediction
    initial
    begin
        int            gap;
        fifo_outcome_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            outcomes_seen++;
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no request waiting",
                                          outcomes_seen));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("accepted", int'(accepted), int'(want.accepted));
                check_field("overflow", int'(overflow), int'(want.overflow));
                check_field("got_byte", int'(got_byte), int'(want.got_byte));
                check_field("out_byte", int'(out_byte), int'(want.out_byte));
                check_field("flow_request", int'(flow_request), int'(want.flow_request));
                check_field("fill_level", int'(fill_level), int'(want.fill_level));
            end
        end
    end

    // End the run when no request moves on any channel for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            shadow_store[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hysteresis_defaults();
        test_overflow_and_skip();
        test_limit_extremes();
        test_random_traffic();

        // Drain, then allow time for any stray result to show
        wait_for_outcomes();
        repeat (20) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      pending_outcomes.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
